FILE: rtl/fpd_pkg.sv
`default_nettype none
package fpd_pkg;

  localparam int RingDepthDefault = 16;

  localparam logic [2:0] PH_PAD    = 3'd0;
  localparam logic [2:0] PH_BOOST  = 3'd1;
  localparam logic [2:0] PH_DROGUE = 3'd2;
  localparam logic [2:0] PH_MAIN   = 3'd3;
  localparam logic [2:0] PH_LANDED = 3'd4;

  localparam logic [2:0] REG_LAUNCH_RISE    = 3'd0;
  localparam logic [2:0] REG_LAUNCH_COUNT   = 3'd1;
  localparam logic [2:0] REG_APOGEE_COUNT   = 3'd2;
  localparam logic [2:0] REG_MAIN_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_MAIN_COUNT     = 3'd4;
  localparam logic [2:0] REG_LANDING_CHANGE = 3'd5;
  localparam logic [2:0] REG_LANDING_COUNT  = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_DECIDE
  } top_state_t;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_SWEEP,
    SL_LO,
    SL_HI,
    SL_SUB
  } slope_state_t;

  typedef struct packed {
    logic done;
    logic negative;
  } slope_stat_t;

endpackage
`default_nettype wire

FILE: rtl/fpd_slope.sv
`default_nettype none
module fpd_slope #(
  parameter int RING_DEPTH = fpd_pkg::RingDepthDefault
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          wr_en,
  input  wire [$clog2(RING_DEPTH)-1:0] wr_idx,
  input  wire [31:0]                   wr_time,
  input  wire signed [17:0]            wr_height,
  input  wire                          start,
  output fpd_pkg::slope_stat_t         stat
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int ST_W = 32 + IW;
  localparam int SH_W = 18 + IW;
  localparam int STH_W = 51 + IW;
  localparam int PA_W = STH_W + IW + 2;
  localparam int HALF = (ST_W + 1) / 2;
  localparam int NUM_W = 52 + 2 * IW + 3;

  logic [31:0]        mem_t [RING_DEPTH];
  logic signed [17:0] mem_h [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [31:0]        rd_t;
  logic signed [17:0] rd_h;
  logic               rd_v;

  fpd_pkg::slope_state_t state, state_next;
  logic [CW-1:0] cnt;
  logic          issue;
  logic          p1, p2;
  logic [31:0]        t1;
  logic signed [17:0] h1;
  logic signed [50:0] prod;
  logic [ST_W-1:0]         sum_t;
  logic signed [SH_W-1:0]  sum_h;
  logic signed [STH_W-1:0] sum_th;
  logic [31:0] t_first;
  logic        first_seen, spread;
  logic signed [PA_W-1:0]  pp_a;
  logic signed [HALF+SH_W:0] pp_lo;
  logic signed [ST_W-HALF+SH_W:0] pp_hi;
  logic signed [NUM_W-1:0] num;

  assign issue = (state == fpd_pkg::SL_SWEEP) && (cnt < CW'(RING_DEPTH));
  assign t1 = rd_v ? rd_t : 32'd0;
  assign h1 = rd_v ? rd_h : 18'sd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_t[wr_idx] <= wr_time;
      mem_h[wr_idx] <= wr_height;
    end
    rd_t <= mem_t[cnt[IW-1:0]];
    rd_h <= mem_h[cnt[IW-1:0]];
    rd_v <= vld[cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpd_pkg::SL_IDLE:  if (start) state_next = fpd_pkg::SL_SWEEP;
      fpd_pkg::SL_SWEEP: begin
        if (!issue && !p1 && !p2) state_next = fpd_pkg::SL_LO;
      end
      fpd_pkg::SL_LO:    state_next = fpd_pkg::SL_HI;
      fpd_pkg::SL_HI:    state_next = fpd_pkg::SL_SUB;
      fpd_pkg::SL_SUB:   state_next = fpd_pkg::SL_IDLE;
      default:           state_next = fpd_pkg::SL_IDLE;
    endcase
  end

  always_comb begin
    num = NUM_W'(pp_a) - (NUM_W'(pp_hi) <<< HALF) - NUM_W'(pp_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpd_pkg::SL_IDLE;
      cnt <= '0;
      p1 <= 1'b0;
      p2 <= 1'b0;
      stat <= '0;
    end else begin
      state <= state_next;
      p1 <= issue;
      p2 <= p1;
      stat.done <= (state == fpd_pkg::SL_SUB);
      if (start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (state == fpd_pkg::SL_SUB) begin
        stat.negative <= spread && (num < 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_t <= '0;
      sum_h <= '0;
      sum_th <= '0;
      first_seen <= 1'b0;
      spread <= 1'b0;
    end else begin
      if (p1) begin
        prod <= $signed({1'b0, t1}) * h1;
        sum_t <= sum_t + ST_W'(t1);
        sum_h <= sum_h + SH_W'(h1);
        if (!first_seen) begin
          first_seen <= 1'b1;
          t_first <= t1;
        end else if (t1 != t_first) begin
          spread <= 1'b1;
        end
      end
      if (p2) begin
        sum_th <= sum_th + STH_W'(prod);
      end
    end
    if (state == fpd_pkg::SL_LO) begin
      pp_a <= PA_W'(sum_th) * $signed(PA_W'(RING_DEPTH));
      pp_lo <= $signed({1'b0, sum_t[HALF-1:0]}) * sum_h;
    end
    if (state == fpd_pkg::SL_HI) begin
      pp_hi <= $signed({1'b0, sum_t[ST_W-1:HALF]}) * sum_h;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/flight_phase_detector_top.sv
`default_nettype none
// Channel  Direction  Handshake         Payload
// s        in         s_tvalid/tready   s_tdata, s_tuser
// m        out        m_tvalid/tready   m_tdata
// cfg      in         cfg_valid/ready   cfg_index, cfg_data
// A word goes from the idle state to the decide state, through the regression state
// in the boost phase, where the regression walks the ring memory one entry per cycle
// and then forms the numerator with two partial products.
// Reset clears the phase state and the ring valid bits and loads the default configuration.
// A finished result waits in the output register; the next word is accepted meanwhile.
module flight_phase_detector_top #(
  parameter int RING_DEPTH = fpd_pkg::RingDepthDefault
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [71:0] s_tdata,   // tick_ms, sample_altitude, phase_altitude, zero fill
  input  wire        s_tuser,   // launch_enabled
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // agl_altitude, flight_phase, fire_drogue, fire_main,
                                // phase_changed, low_apogee
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_data
);

  localparam int IW = $clog2(RING_DEPTH);

  logic [15:0] launch_rise, main_height, landing_change;
  logic [7:0]  launch_count, apogee_count, main_count, landing_count;

  fpd_pkg::top_state_t state, state_next;
  logic [2:0]  phase, phase_next;
  logic [7:0]  dcount, dcount_next;
  logic signed [16:0] ground, ground_next, prev, prev_next;
  logic signed [17:0] apogee, apogee_next;
  logic [IW-1:0] ring_index;

  logic signed [16:0] alt_q;
  logic               en_q;
  logic signed [17:0] agl_q;
  logic signed [17:0] agl;
  logic               accept, start, load_out;
  logic drogue, mainf, changed, low;
  logic [7:0] bumped;
  logic signed [17:0] rise, diff, adiff;
  fpd_pkg::slope_stat_t stat;

  assign cfg_ready = 1'b1;
  assign accept = s_tvalid && s_tready;
  assign agl = $signed({2'b00, s_tdata[47:32]}) - 18'(ground);
  assign start = accept && (phase == fpd_pkg::PH_BOOST);
  assign bumped = (dcount == 8'hFF) ? dcount : dcount + 8'd1;
  assign rise = 18'(alt_q) - 18'(ground);
  assign diff = 18'(alt_q) - 18'(prev);
  assign adiff = diff[17] ? -diff : diff;

  fpd_slope #(.RING_DEPTH(RING_DEPTH)) u_slope (
    .clk(clk), .rst(rst), .wr_en(accept), .wr_idx(ring_index),
    .wr_time(s_tdata[31:0]), .wr_height(agl), .start(start), .stat(stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      fpd_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (phase == fpd_pkg::PH_BOOST) ? fpd_pkg::ST_SLOPE
                                                    : fpd_pkg::ST_DECIDE;
        end
      end
      fpd_pkg::ST_SLOPE:  if (stat.done) state_next = fpd_pkg::ST_DECIDE;
      fpd_pkg::ST_DECIDE: if (!m_tvalid || m_tready) state_next = fpd_pkg::ST_IDLE;
      default:            state_next = fpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == fpd_pkg::ST_IDLE);
    load_out = (state == fpd_pkg::ST_DECIDE) && (!m_tvalid || m_tready);
  end

  always_comb begin
    phase_next = phase;
    dcount_next = dcount;
    ground_next = ground;
    prev_next = prev;
    apogee_next = apogee;
    drogue = 1'b0;
    mainf = 1'b0;
    changed = 1'b0;
    low = 1'b0;
    case (phase)
      fpd_pkg::PH_PAD: begin
        if (!en_q) begin
          ground_next = alt_q;
          dcount_next = 8'd0;
        end else if (rise > $signed({2'b00, launch_rise})) begin
          dcount_next = bumped;
          if (bumped > launch_count) begin
            phase_next = fpd_pkg::PH_BOOST;
            dcount_next = 8'd0;
            changed = 1'b1;
          end
        end else begin
          dcount_next = 8'd0;
        end
      end
      fpd_pkg::PH_BOOST: begin
        if (stat.negative) begin
          dcount_next = bumped;
          if (bumped > apogee_count) begin
            phase_next = fpd_pkg::PH_DROGUE;
            dcount_next = 8'd0;
            changed = 1'b1;
            drogue = 1'b1;
            apogee_next = rise;
            low = rise < $signed({2'b00, main_height});
          end
        end else begin
          dcount_next = 8'd0;
        end
      end
      fpd_pkg::PH_DROGUE: begin
        if (rise < $signed({2'b00, main_height})) begin
          dcount_next = bumped;
          if (bumped > main_count) begin
            phase_next = fpd_pkg::PH_MAIN;
            dcount_next = 8'd0;
            changed = 1'b1;
            mainf = 1'b1;
            prev_next = alt_q;
          end
        end else begin
          dcount_next = 8'd0;
        end
      end
      fpd_pkg::PH_MAIN: begin
        if (adiff < $signed({2'b00, landing_change})) begin
          dcount_next = bumped;
          if (bumped > landing_count) begin
            phase_next = fpd_pkg::PH_LANDED;
            dcount_next = 8'd0;
            changed = 1'b1;
          end
        end else begin
          dcount_next = 8'd0;
        end
        prev_next = alt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_rise <= 16'd100;
      launch_count <= 8'd5;
      apogee_count <= 8'd5;
      main_height <= 16'd1500;
      main_count <= 8'd5;
      landing_change <= 16'd2;
      landing_count <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpd_pkg::REG_LAUNCH_RISE:    launch_rise <= cfg_data;
        fpd_pkg::REG_LAUNCH_COUNT:   launch_count <= cfg_data[7:0];
        fpd_pkg::REG_APOGEE_COUNT:   apogee_count <= cfg_data[7:0];
        fpd_pkg::REG_MAIN_HEIGHT:    main_height <= cfg_data;
        fpd_pkg::REG_MAIN_COUNT:     main_count <= cfg_data[7:0];
        fpd_pkg::REG_LANDING_CHANGE: landing_change <= cfg_data;
        fpd_pkg::REG_LANDING_COUNT:  landing_count <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpd_pkg::ST_IDLE;
      phase <= fpd_pkg::PH_PAD;
      dcount <= 8'd0;
      ground <= '0;
      prev <= '0;
      apogee <= '0;
      ring_index <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ring_index <= (ring_index == IW'(RING_DEPTH - 1)) ? '0 : ring_index + IW'(1);
      end
      m_tvalid <= load_out || (m_tvalid && !m_tready);
      if (load_out) begin
        phase <= phase_next;
        dcount <= dcount_next;
        ground <= ground_next;
        prev <= prev_next;
        apogee <= apogee_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alt_q <= s_tdata[64:48];
      en_q <= s_tuser;
      agl_q <= agl;
    end
    if (load_out) begin
      m_tdata[16:0] <= (agl_q > 18'sd65535) ? 17'h0FFFF : agl_q[16:0];
      m_tdata[19:17] <= phase_next;
      m_tdata[20] <= drogue;
      m_tdata[21] <= mainf;
      m_tdata[22] <= changed;
      m_tdata[23] <= low;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == fpd_pkg::ST_SLOPE |-> phase == fpd_pkg::PH_BOOST)
    else $error("regression running outside boost phase");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[19:17] == fpd_pkg::PH_DROGUE)
    else $error("drogue fired outside drogue transition");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> m_tdata[19:17] == fpd_pkg::PH_MAIN)
    else $error("main fired outside main transition");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23] |-> m_tdata[20])
    else $error("low apogee flag without apogee");

endmodule
`default_nettype wire

FILE: tb/tb_flight_phase_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_flight_phase_detector_top;

  localparam int RING = 16;
  localparam int LIMIT = 2000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [16:0] agl;
    logic [2:0] ph;
    logic drogue;
    logic main_fire;
    logic changed;
    logic low;
  } flight_out_t;

  typedef struct {
    logic [31:0] tick;
    logic [15:0] sample;
    logic signed [16:0] alt;
    logic en;
    logic typed;
    logic signed [16:0] agl;
    logic [2:0] ph;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  flight_phase_detector_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  flight_out_t pending_q[$];

  int rise_cfg, lcount_cfg, acount_cfg, mheight_cfg, mcount_cfg, lchange_cfg, ldcount_cfg;
  logic [2:0] fl_phase;
  int debounce, ground, prev_alt, apogee;
  int ring_pos;
  logic [31:0] tick_ring[RING];
  int height_ring[RING];
  int reached[5];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    flight_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word %h", m_tdata));
      end else begin
        e = pending_q.pop_front();
        words_checked++;
        if (m_tdata[16:0] !== e.agl || m_tdata[19:17] !== e.ph || m_tdata[20] !== e.drogue ||
            m_tdata[21] !== e.main_fire || m_tdata[22] !== e.changed ||
            m_tdata[23] !== e.low) begin
          report($sformatf("word %0d got agl %0d ph %0d dr %b mn %b ch %b lo %b, want %0d %0d %b %b %b %b",
            words_checked, $signed(m_tdata[16:0]), m_tdata[19:17], m_tdata[20], m_tdata[21],
            m_tdata[22], m_tdata[23], e.agl, e.ph, e.drogue, e.main_fire, e.changed, e.low));
        end
      end
    end
  end

  function automatic bit slope_falling();
    longint num;
    longint dt;
    bit spread;
    num = 0;
    spread = 0;
    for (int i = 0; i < RING; i++) begin
      for (int j = i + 1; j < RING; j++) begin
        dt = longint'(tick_ring[i]) - longint'(tick_ring[j]);
        if (dt != 0) spread = 1;
        num += dt * longint'(height_ring[i] - height_ring[j]);
      end
    end
    return spread && num < 0;
  endfunction

  function automatic void count_up();
    if (debounce < 255) debounce++;
  endfunction

  function automatic flight_out_t advance_flight(input logic [31:0] tick, input logic [15:0] sample,
                                                 input logic signed [16:0] alt_in, input logic en);
    flight_out_t r;
    int agl;
    int alt;
    int d;
    alt = alt_in;
    r = '{default: '0};
    agl = int'(sample) - ground;
    height_ring[ring_pos] = agl;
    tick_ring[ring_pos] = tick;
    ring_pos = (ring_pos == RING - 1) ? 0 : ring_pos + 1;
    case (fl_phase)
      fpd_pkg::PH_PAD: begin
        if (!en) begin
          ground = alt;
          debounce = 0;
        end else if (alt - ground > rise_cfg) begin
          count_up();
          if (debounce > lcount_cfg) begin
            fl_phase = fpd_pkg::PH_BOOST; debounce = 0; r.changed = 1;
          end
        end else begin
          debounce = 0;
        end
      end
      fpd_pkg::PH_BOOST: begin
        if (slope_falling()) begin
          count_up();
          if (debounce > acount_cfg) begin
            fl_phase = fpd_pkg::PH_DROGUE; debounce = 0; r.changed = 1; r.drogue = 1;
            apogee = alt - ground;
            r.low = apogee < mheight_cfg;
          end
        end else begin
          debounce = 0;
        end
      end
      fpd_pkg::PH_DROGUE: begin
        if (alt - ground < mheight_cfg) begin
          count_up();
          if (debounce > mcount_cfg) begin
            fl_phase = fpd_pkg::PH_MAIN; debounce = 0; r.changed = 1; r.main_fire = 1;
            prev_alt = alt;
          end
        end else begin
          debounce = 0;
        end
      end
      fpd_pkg::PH_MAIN: begin
        d = alt - prev_alt;
        if (d < 0) d = -d;
        if (d < lchange_cfg) begin
          count_up();
          if (debounce > ldcount_cfg) begin
            fl_phase = fpd_pkg::PH_LANDED; debounce = 0; r.changed = 1;
          end
        end else begin
          debounce = 0;
        end
        prev_alt = alt;
      end
      default: ;
    endcase
    r.agl = (agl > 65535) ? 17'sd65535 : agl[16:0];
    r.ph = fl_phase;
    return r;
  endfunction

  task automatic send(input logic [31:0] tick, input logic [15:0] sample,
                      input logic signed [16:0] alt, input logic en,
                      input logic typed = 0, input logic signed [16:0] agl = 0,
                      input logic [2:0] ph = 0);
    flight_out_t r;
    case ((words_sent / 100) % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 85; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 85; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, alt, sample, tick};
    s_tuser <= en;
    do @(posedge clk); while (!s_tready);
    r = advance_flight(tick, sample, alt, en);
    if (typed) begin
      r.agl = agl;
      r.ph = ph;
    end
    pending_q.push_back(r);
    reached[fl_phase]++;
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      fpd_pkg::REG_LAUNCH_RISE: rise_cfg = val;
      fpd_pkg::REG_LAUNCH_COUNT: lcount_cfg = val[7:0];
      fpd_pkg::REG_APOGEE_COUNT: acount_cfg = val[7:0];
      fpd_pkg::REG_MAIN_HEIGHT: mheight_cfg = val;
      fpd_pkg::REG_MAIN_COUNT: mcount_cfg = val[7:0];
      fpd_pkg::REG_LANDING_CHANGE: lchange_cfg = val;
      fpd_pkg::REG_LANDING_COUNT: ldcount_cfg = val[7:0];
      default: ;
    endcase
  endtask

  logic [31:0] now_ms = 0;

  task automatic send_random(input int n);
    for (int k = 0; k < n; k++) begin
      now_ms = ($urandom_range(9) == 0) ? $urandom : now_ms + $urandom_range(3);
      send(now_ms, 16'($urandom), 17'($urandom), 1'($urandom_range(1)));
    end
  endtask

  row_t table_rows[] = '{
    '{32'd0, 16'd0, 17'sd0, 1'b0, 1'b1, 17'sd0, fpd_pkg::PH_PAD},
    '{32'hFFFFFFFF, 16'hFFFF, -17'sd65536, 1'b0, 1'b1, 17'sd65535, fpd_pkg::PH_PAD},
    '{32'd5, 16'hFFFF, 17'sd65535, 1'b0, 1'b1, 17'sd65535, fpd_pkg::PH_PAD},
    '{32'd6, 16'd0, 17'sd0, 1'b1, 1'b1, -17'sd65535, fpd_pkg::PH_PAD},
    '{32'd7, 16'd100, 17'sd1000, 1'b0, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd8, 16'd1100, 17'sd1100, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd9, 16'd1101, 17'sd1101, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd10, 16'd1200, 17'sd1100, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd11, 16'd1500, 17'sd1500, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd12, 16'd2000, 17'sd2000, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd13, 16'd2500, 17'sd2500, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'd14, 16'd500, -17'sd500, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'h80000000, 16'h8000, 17'sd100, 1'b0, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'h80000001, 16'h7FFF, 17'sd201, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'h80000002, 16'h0001, 17'sd200, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'h80000003, 16'hAAAA, -17'sd1, 1'b0, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'h55555555, 16'h5555, 17'sd21845, 1'b0, 1'b0, 17'sd0, fpd_pkg::PH_PAD},
    '{32'hAAAAAAAA, 16'hAAAA, -17'sd21846, 1'b1, 1'b0, 17'sd0, fpd_pkg::PH_PAD}
  };

  initial begin
    int g;
    int h;
    int guard;
    rise_cfg = 100; lcount_cfg = 5; acount_cfg = 5; mheight_cfg = 1500;
    mcount_cfg = 5; lchange_cfg = 2; ldcount_cfg = 20;
    fl_phase = fpd_pkg::PH_PAD; debounce = 0; ground = 0; prev_alt = 0; apogee = 0;
    ring_pos = 0;
    for (int i = 0; i < RING; i++) begin
      tick_ring[i] = 0;
      height_ring[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (table_rows[i])
      send(table_rows[i].tick, table_rows[i].sample, table_rows[i].alt, table_rows[i].en,
           table_rows[i].typed, table_rows[i].agl, table_rows[i].ph);

    // The pad phase cannot be left while the launch count sits at its ceiling.
    drain();
    write_reg(fpd_pkg::REG_LAUNCH_COUNT, 16'hFFFF);
    write_reg(fpd_pkg::REG_LAUNCH_RISE, 16'd0);
    write_reg(REG_UNUSED, 16'($urandom));
    send_random(150);
    drain();
    write_reg(fpd_pkg::REG_LAUNCH_RISE, 16'hFFFF);
    send_random(150);
    drain();
    write_reg(fpd_pkg::REG_LAUNCH_RISE, 16'($urandom));
    send_random(150);

    drain();
    write_reg(fpd_pkg::REG_LAUNCH_RISE, 16'($urandom_range(500)));
    write_reg(fpd_pkg::REG_LAUNCH_COUNT, 16'($urandom_range(3)));
    write_reg(fpd_pkg::REG_APOGEE_COUNT, 16'hFF00 | 16'hFF);
    g = int'($urandom_range(3000));
    send(now_ms, 16'(g), 17'(g), 1'b0);
    guard = 0;
    while (fl_phase == fpd_pkg::PH_PAD && guard < 100) begin
      now_ms = now_ms + 32'd10;
      send(now_ms, 16'(g + 600 + guard), 17'(g + 600 + guard), 1'b1);
      guard++;
    end

    send_random(350);

    drain();
    write_reg(fpd_pkg::REG_APOGEE_COUNT, 16'($urandom_range(4)));
    write_reg(fpd_pkg::REG_MAIN_HEIGHT, 16'($urandom_range(1, 65535)));
    h = 40000;
    guard = 0;
    while (fl_phase == fpd_pkg::PH_BOOST && guard < 200) begin
      now_ms = now_ms + 32'(1 + $urandom_range(20));
      h = h - int'($urandom_range(1, 200));
      send(now_ms, 16'(h), 17'($urandom), 1'($urandom_range(1)));
      guard++;
    end

    drain();
    write_reg(fpd_pkg::REG_MAIN_COUNT, 16'h00FF);
    write_reg(fpd_pkg::REG_MAIN_HEIGHT, 16'hFFFF);
    send_random(80);
    drain();
    write_reg(fpd_pkg::REG_MAIN_HEIGHT, 16'd0);
    send_random(70);
    drain();
    write_reg(fpd_pkg::REG_MAIN_HEIGHT, 16'd2000);
    write_reg(fpd_pkg::REG_MAIN_COUNT, 16'($urandom_range(3)));
    guard = 0;
    while (fl_phase == fpd_pkg::PH_DROGUE && guard < 100) begin
      send(now_ms, 16'($urandom), 17'(ground), 1'($urandom_range(1)));
      guard++;
    end

    drain();
    write_reg(fpd_pkg::REG_LANDING_COUNT, 16'hFFFF);
    write_reg(fpd_pkg::REG_LANDING_CHANGE, 16'd0);
    send_random(60);
    drain();
    write_reg(fpd_pkg::REG_LANDING_CHANGE, 16'hFFFF);
    send_random(50);
    drain();
    write_reg(fpd_pkg::REG_LANDING_CHANGE, 16'($urandom_range(8)));
    send_random(50);
    drain();
    write_reg(fpd_pkg::REG_LANDING_CHANGE, 16'd2);
    write_reg(fpd_pkg::REG_LANDING_COUNT, 16'($urandom_range(4)));
    g = int'($urandom_range(2000));
    guard = 0;
    while (fl_phase == fpd_pkg::PH_MAIN && guard < 100) begin
      send(now_ms, 16'($urandom), 17'(g + guard % 2), 1'($urandom_range(1)));
      guard++;
    end

    send_random(100);

    drain();
    $display("Sent %0d words and checked %0d results; words per phase pad %0d boost %0d",
             words_sent, words_checked, reached[0], reached[1]);
    $display("drogue %0d main %0d landed %0d, under four idle and stall mixes.",
             reached[2], reached[3], reached[4]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
